FILE: src/ssl_pkg.sv
// ----------------------------------------------------------------------------
// ssl_pkg: shared definitions for the shaped slew limiter
// Field widths, register indexes, arithmetic constants and the sequencer
// state type.
// ----------------------------------------------------------------------------
`default_nettype none

package ssl_pkg;

    localparam int NUM_CHANNELS = 16;

    localparam int CH_W    = 4;
    localparam int SMP_W   = 16;
    localparam int HELD_W  = 32;
    localparam int STEP_W  = 25;
    localparam int SHAPE_W = 17;
    localparam int MUL_W   = 32;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // Q1.16 value of one; larger shape settings saturate here.
    localparam logic [SHAPE_W-1:0] SHAPE_ONE = 17'd65536;

    // ceil(2^35 / 10): floor(v * DIV10_RECIP / 2^35) equals floor(v / 10)
    // for every v below 2^34.
    localparam logic [MUL_W-1:0] DIV10_RECIP = 32'd3435973837;

    localparam logic [1:0] REG_RISE  = 2'd0;
    localparam logic [1:0] REG_FALL  = 2'd1;
    localparam logic [1:0] REG_SHAPE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_MUL_LIN,
        ST_MUL_Q,
        ST_MUL_P,
        ST_MUL_DIV,
        ST_UPDATE,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

FILE: src/shaped_slew_limiter_top.sv
// ----------------------------------------------------------------------------
// shaped_slew_limiter_top: polyphonic slew limiter with rise/fall rates and
// a shape blend between linear and distance-proportional slew.
//
// Usage: an input transaction (channel, sample_in) is taken when in_valid is
// high and in_stall is low. The channel's held value moves toward the sample
// and the result (channel_out, sample_out) is offered with out_valid until
// the receiver takes it with out_stall low. One result per input.
// The block works on one transaction at a time. After the input transaction
// it reads the held value, makes four passes through the single shared 32x32
// multiplier, updates the held value and offers the result; once the result
// is taken it returns to idle, where it takes the next transaction.
// in_stall stays high from the input transaction until the result has been
// taken, so a stalled receiver holds off the sender.
// Reset clears the step and shape registers and every channel's held value.
// The APB port writes rise_step (0x0), fall_step (0x4) and shape_amount
// (0x8); configuration must be changed only while the block is idle, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module shaped_slew_limiter_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [ssl_pkg::CH_W-1:0]    channel,
    input  wire logic [ssl_pkg::SMP_W-1:0]   sample_in,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [ssl_pkg::CH_W-1:0]         channel_out,
    output logic [ssl_pkg::SMP_W-1:0]        sample_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ssl_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ssl_pkg::DATA_W-1:0]  pwdata,
    output logic [ssl_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);
    import ssl_pkg::*;

    state_t state_reg, state_next;

    logic [STEP_W-1:0]  rise_reg;
    logic [STEP_W-1:0]  fall_reg;
    logic [SHAPE_W-1:0] shape_reg;

    logic [HELD_W-1:0]  held_reg [NUM_CHANNELS];

    logic [CH_W-1:0]          ch_reg;
    logic signed [HELD_W-1:0] tgt_reg;
    logic signed [HELD_W-1:0] h_reg;
    logic [HELD_W-1:0]        mag_reg;
    logic                     up_reg;
    logic                     bad_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [STEP_W-1:0]        lin_reg;
    logic [MUL_W-1:0]         q_reg;
    logic [29:0]              v_reg;
    logic [26:0]              prop_reg;
    logic [SMP_W-1:0]         smp_out_reg;

    logic                     in_acc;
    logic                     wr_en;
    logic [SHAPE_W-1:0]       shp;
    logic                     ch_bad;
    logic signed [HELD_W-1:0] held_rd;
    logic signed [HELD_W:0]   diff;
    logic [MUL_W-1:0]         mul_a;
    logic [MUL_W-1:0]         mul_b;
    logic [2*MUL_W-1:0]       prod;
    logic [27:0]              move;
    logic [HELD_W:0]          h_step;
    logic [HELD_W-1:0]        h_new;

    assign in_acc = in_valid && !in_stall;
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    assign shp    = (shape_reg > SHAPE_ONE) ? SHAPE_ONE : shape_reg;
    assign ch_bad = {1'b0, ch_reg} >= (CH_W+1)'(NUM_CHANNELS);

    assign held_rd = ch_bad ? '0 : held_reg[ch_reg];

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_reg  <= '0;
            fall_reg  <= '0;
            shape_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_RISE:  rise_reg  <= pwdata[STEP_W-1:0];
                REG_FALL:  fall_reg  <= pwdata[STEP_W-1:0];
                REG_SHAPE: shape_reg <= pwdata[SHAPE_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_RISE:  prdata = {{(DATA_W-STEP_W){1'b0}}, rise_reg};
            REG_FALL:  prdata = {{(DATA_W-STEP_W){1'b0}}, fall_reg};
            REG_SHAPE: prdata = {{(DATA_W-SHAPE_W){1'b0}}, shape_reg};
            default:   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Held values, one per channel
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
                held_reg[i] <= '0;
        end
        else if (state_reg == ST_UPDATE && !bad_reg)
        begin
            held_reg[ch_reg] <= h_new;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_DIST;
            ST_DIST:    state_next = ST_MUL_LIN;
            ST_MUL_LIN: state_next = ST_MUL_Q;
            ST_MUL_Q:   state_next = ST_MUL_P;
            ST_MUL_P:   state_next = ST_MUL_DIV;
            ST_MUL_DIV: state_next = ST_UPDATE;
            ST_UPDATE:  state_next = ST_OUT;
            ST_OUT:     if (!out_stall) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs and operand selection for the shared multiplier.
    always_comb
    begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_MUL_LIN:
            begin
                mul_a = {{(MUL_W-STEP_W){1'b0}}, step_reg};
                mul_b = {{(MUL_W-SHAPE_W){1'b0}}, SHAPE_ONE - shp};
            end
            ST_MUL_Q:
            begin
                mul_a = {{(MUL_W-SHAPE_W){1'b0}}, shp};
                mul_b = mag_reg;
            end
            ST_MUL_P:
            begin
                mul_a = q_reg;
                mul_b = {{(MUL_W-STEP_W){1'b0}}, step_reg};
            end
            ST_MUL_DIV:
            begin
                mul_a = {2'b00, v_reg};
                mul_b = DIV10_RECIP;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    assign prod = mul_a * mul_b;

    assign diff = {tgt_reg[HELD_W-1], tgt_reg} - {h_reg[HELD_W-1], h_reg};

    assign move   = {3'b000, lin_reg} + {1'b0, prop_reg};
    assign h_step = up_reg ? ({h_reg[HELD_W-1], h_reg} + {5'b00000, move})
                           : ({h_reg[HELD_W-1], h_reg} - {5'b00000, move});

    // A move that reaches the distance lands exactly on the target.
    always_comb
    begin
        if (mag_reg == '0)
            h_new = h_reg;
        else if ({4'b0000, move} >= mag_reg)
            h_new = tgt_reg;
        else
            h_new = h_step[HELD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    ch_reg  <= channel;
                    tgt_reg <= {sample_in, 16'h0000};
                end
            end
            ST_DIST:
            begin
                h_reg    <= held_rd;
                bad_reg  <= ch_bad;
                // The direction follows from a compare, so the step is ready
                // for the first multiply.
                step_reg <= (tgt_reg < held_rd) ? fall_reg : rise_reg;
            end
            ST_MUL_LIN:
            begin
                // Distance is taken in the cycle after the held value is read.
                up_reg  <= !diff[HELD_W];
                mag_reg <= diff[HELD_W] ? 32'(-diff) : diff[HELD_W-1:0];
                lin_reg <= prod[STEP_W+15:16];
            end
            ST_MUL_Q:
            begin
                q_reg <= prod[47:16];
            end
            ST_MUL_P:
            begin
                v_reg <= prod[56:27];
            end
            ST_MUL_DIV:
            begin
                prop_reg <= prod[61:35];
            end
            ST_UPDATE:
            begin
                smp_out_reg <= bad_reg ? '0 : h_new[HELD_W-1:HELD_W-SMP_W];
            end
            default:
            begin
            end
        endcase
    end

    assign channel_out = ch_reg;
    assign sample_out  = smp_out_reg;

endmodule

`default_nettype wire

FILE: src/ssl_checker.sv
// ----------------------------------------------------------------------------
// ssl_checker: port-level checks for the shaped slew limiter
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_stall,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic [ssl_pkg::CH_W-1:0]   channel_out,
    input wire logic [ssl_pkg::SMP_W-1:0]  sample_out
);

    // A result waiting at the output holds while stalled.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable(channel_out) && $stable(sample_out))
        else $error("stalled output transaction changed or dropped");

    // The block works on one transaction at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again before the result was delivered");

    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while a result is pending");

    // A result never appears in the cycle right after the input transaction.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("result offered too early");

endmodule

bind shaped_slew_limiter_top ssl_checker u_ssl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .channel_out (channel_out),
    .sample_out  (sample_out)
);

`default_nettype wire
